### src/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Operation codes, widths and the controller-to-datapath command structs.
// ----------------------------------------------------------------------------
`default_nettype none
package mau_pkg;

   localparam int unsigned Width = 32;

   typedef logic [Width-1:0] word_type;
   typedef logic [2:0]       func_type;

   localparam func_type FUNC_ADD = 3'd0;
   localparam func_type FUNC_SUB = 3'd1;
   localparam func_type FUNC_MUL = 3'd2;
   localparam func_type FUNC_POW = 3'd3;
   localparam func_type FUNC_INV = 3'd4;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // latch operands, start reducing a and b
      OP_RED_STEP,  // one bit of operand reduction
      OP_ADDSUB,    // add or subtract of reduced operands
      OP_MUL_INIT,  // start x*y mod m (selects operands by mul_sel)
      OP_MUL_STEP,  // one bit of shift-add multiply
      OP_MUL_DONE,  // write product back (by mul_sel)
      OP_EXP_SHIFT, // shift exponent right, copy acc to result
      OP_INV_INIT,  // set up Euclid
      OP_DIV_INIT,  // start quotient r / nr
      OP_DIV_STEP,  // one bit of restoring division
      OP_INV_UPD,   // apply quotient to r and t
      OP_INV_FIN,   // finish inverse
      OP_ERROR      // result 0, status 1
   } op_type;

   // which multiply: product a*b, acc*sq, or sq*sq
   typedef enum logic [1:0] {
      MSEL_AB,
      MSEL_ACC,
      MSEL_SQ
   } msel_type;

   typedef struct packed {
      op_type   op;
      msel_type mul_sel;
   } cmd_type;

   typedef struct packed {
      logic red_done;
      logic mul_done;
      logic div_done;
      logic exp_zero;
      logic exp_lsb;
      logic nr_zero;
      logic mod_small;
   } sts_type;

endpackage
`default_nettype wire

### src/mau_if.sv
// ----------------------------------------------------------------------------
// mau_req_if / mau_rsp_if: valid-ready channels of the unit
// Request carries func and two operands, response carries result and status.
// ----------------------------------------------------------------------------
`default_nettype none
interface mau_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] operand_a;
   logic [31:0] operand_b;
   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        status;
   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

### src/mau_datapath.sv
// ----------------------------------------------------------------------------
// mau_datapath: registers and bit-serial units of the arithmetic unit
// Shift-subtract reduction, shift-add modular multiply, restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  wire mau_pkg::word_type modulus,
   input  wire mau_pkg::func_type req_func,
   input  wire mau_pkg::word_type req_a,
   input  wire mau_pkg::word_type req_b,
   input  wire mau_pkg::cmd_type  cmd,
   output mau_pkg::sts_type       sts,
   output mau_pkg::word_type      result,
   output logic                  err
);
   import mau_pkg::*;

   localparam int unsigned CntW = $clog2(Width + 1);

   // Operand and working registers
   word_type   a_ff, a_in, b_ff, b_in, e_ff, e_in;
   word_type   ra_ff, ra_in, rb_ff, rb_in;   // reduction remainders
   word_type   acc_ff, acc_in, sq_ff, sq_in;
   word_type   mx_ff, mx_in, my_ff, my_in, mp_ff, mp_in;
   word_type   r_ff, r_in, nr_ff, nr_in, dr_ff, dr_in;
   logic [Width:0] t_ff, t_in, nt_ff, nt_in, tp_ff, tp_in; // signed, two's complement
   logic [CntW-1:0] cnt_ff, cnt_in;
   word_type   res_ff, res_in;
   logic       err_ff, err_in;
   func_type   fn_ff, fn_in;

   // bit-serial helpers
   logic [Width:0] ra_sh, rb_sh, mp_dbl, dr_sh;
   logic [Width:0] sum_ab, sub_ab;
   logic [Width:0] t_new;
   logic           q_bit;
   word_type       mulx, muly;
   logic           is_wrap;

   assign is_wrap = (modulus == '0);

   // reduce (2*r + bit) mod m, value stays below 2m
   function automatic word_type modfix(logic [Width:0] v, word_type m);
      logic [Width:0] d;
      d = v - {1'b0, m};
      return (v >= {1'b0, m}) ? d[Width-1:0] : v[Width-1:0];
   endfunction

   always_comb begin
      ra_sh  = {ra_ff, a_ff[Width-1]};
      rb_sh  = {rb_ff, b_ff[Width-1]};
      mp_dbl = {mp_ff, 1'b0};
      dr_sh  = {dr_ff, mx_ff[Width-1]};
      q_bit  = (dr_sh >= {1'b0, nr_ff});
      mulx   = (cmd.mul_sel == MSEL_AB) ? a_ff : (cmd.mul_sel == MSEL_ACC) ? acc_ff : sq_ff;
      muly   = (cmd.mul_sel == MSEL_AB) ? b_ff : sq_ff;
      sum_ab = {1'b0, a_ff} + {1'b0, b_ff};
      sub_ab = {1'b0, a_ff} + {1'b0, modulus} - {1'b0, b_ff};
      t_new  = t_ff - tp_ff;
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; e_in = e_ff; ra_in = ra_ff; rb_in = rb_ff;
      acc_in = acc_ff; sq_in = sq_ff; mx_in = mx_ff; my_in = my_ff; mp_in = mp_ff;
      r_in = r_ff; nr_in = nr_ff; tp_in = tp_ff; dr_in = dr_ff;
      t_in = t_ff; nt_in = nt_ff; cnt_in = cnt_ff;
      res_in = res_ff; err_in = err_ff; fn_in = fn_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            a_in = req_a; b_in = req_b; e_in = req_b; fn_in = req_func;
            ra_in = '0; rb_in = '0; cnt_in = CntW'(Width);
            err_in = 1'b0; res_in = '0;
            acc_in = (modulus == Width'(1)) ? '0 : Width'(1);
         end
         OP_RED_STEP: begin
            // shift one bit of a and b into the remainders; a,b shift left
            if (is_wrap) begin
               cnt_in = '0;
            end else begin
               ra_in = modfix(ra_sh, modulus);
               rb_in = modfix(rb_sh, modulus);
               a_in  = {a_ff[Width-2:0], 1'b0};
               b_in  = {b_ff[Width-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CntW'(1)) begin
                  a_in = modfix(ra_sh, modulus);
                  b_in = modfix(rb_sh, modulus);
               end
            end
            sq_in = (cnt_ff == CntW'(1) && !is_wrap) ? modfix(ra_sh, modulus) : a_ff;
         end
         OP_ADDSUB: begin
            if (fn_ff == FUNC_ADD)
               res_in = is_wrap ? sum_ab[Width-1:0] : modfix(sum_ab, modulus);
            else
               res_in = is_wrap ? (a_ff - b_ff) : modfix(sub_ab, modulus);
         end
         OP_MUL_INIT: begin
            mx_in = mulx; my_in = muly; mp_in = '0; cnt_in = CntW'(Width);
         end
         OP_MUL_STEP: begin
            // Horner: p = 2p + x*ybit, top bit of y first
            if (is_wrap) begin
               mp_in = mp_ff[Width-1:0] + mp_ff[Width-1:0] +
                       (my_ff[Width-1] ? mx_ff : '0);
            end else begin
               mp_in = modfix(mp_dbl, modulus);
               if (my_ff[Width-1])
                  mp_in = modfix({1'b0, modfix(mp_dbl, modulus)} + {1'b0, mx_ff}, modulus);
            end
            my_in  = {my_ff[Width-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
         OP_MUL_DONE: begin
            unique case (cmd.mul_sel)
               MSEL_AB:  res_in = mp_ff;
               MSEL_ACC: acc_in = mp_ff;
               default:  sq_in  = mp_ff;
            endcase
         end
         OP_EXP_SHIFT: begin
            e_in = {1'b0, e_ff[Width-1:1]};
            res_in = acc_ff;
         end
         OP_INV_INIT: begin
            r_in = modulus; nr_in = a_ff;
            t_in = '0; nt_in = (Width+1)'(1);
         end
         OP_DIV_INIT: begin
            tp_in = '0; dr_in = '0; cnt_in = CntW'(Width);
            // mx shifts the dividend r out top bit first
            mx_in = r_ff;
         end
         OP_DIV_STEP: begin
            if (q_bit)
               dr_in = dr_sh[Width-1:0] - nr_ff;
            else
               dr_in = dr_sh[Width-1:0];
            // running q*nt, quotient bits arrive top first
            tp_in  = {tp_ff[Width-1:0], 1'b0} + (q_bit ? nt_ff : '0);
            mx_in  = {mx_ff[Width-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
         OP_INV_UPD: begin
            // remainder is dr, tp holds q*nt
            r_in  = nr_ff; nr_in = dr_ff;
            t_in  = nt_ff; nt_in = t_new;
         end
         OP_INV_FIN: begin
            if (r_ff != Width'(1)) begin
               err_in = 1'b1; res_in = '0;
            end else begin
               res_in = t_ff[Width] ? (t_ff[Width-1:0] + modulus) : t_ff[Width-1:0];
            end
         end
         OP_ERROR: begin
            err_in = 1'b1; res_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; e_ff <= e_in; ra_ff <= ra_in; rb_ff <= rb_in;
      acc_ff <= acc_in; sq_ff <= sq_in; mx_ff <= mx_in; my_ff <= my_in; mp_ff <= mp_in;
      r_ff <= r_in; nr_ff <= nr_in; tp_ff <= tp_in; dr_ff <= dr_in;
      t_ff <= t_in; nt_ff <= nt_in; res_ff <= res_in; fn_ff <= fn_in;
      if (reset) begin
         cnt_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         err_ff <= err_in;
      end
   end

   // status to controller
   always_comb begin
      sts.red_done  = (cnt_ff == CntW'(1)) || is_wrap;
      sts.mul_done  = (cnt_ff == CntW'(1));
      sts.div_done  = (cnt_ff == CntW'(1));
      sts.exp_zero  = (e_ff == '0);
      sts.exp_lsb   = e_ff[0];
      sts.nr_zero   = (nr_ff == '0);
      sts.mod_small = (modulus[Width-1:1] == '0);
   end

   assign result = res_ff;
   assign err    = err_ff;
endmodule
`default_nettype wire

### src/mau_ctrl.sv
// ----------------------------------------------------------------------------
// mau_ctrl: sequencer of the modular arithmetic unit
// Steps the datapath through reduction, multiply, power and Euclid loops.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire mau_pkg::func_type req_func,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  wire mau_pkg::sts_type  sts,
   output mau_pkg::cmd_type       cmd
);
   import mau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RED, S_DISPATCH, S_MUL_START, S_MUL, S_MUL_END,
      S_POW_TEST, S_POW_SQ, S_INV_START, S_INV_TEST, S_DIV, S_INV_UPD,
      S_ERR, S_OUT
   } state_type;

   state_type state_ff, state_in;
   func_type  fn_ff, fn_in;
   msel_type  msel_ff, msel_in;
   logic      rv_ff, rv_in;

   always_comb begin
      state_in = state_ff; fn_in = fn_ff; msel_in = msel_ff; rv_in = rv_ff;
      cmd.op = OP_NONE; cmd.mul_sel = msel_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op = OP_LOAD; fn_in = req_func; state_in = S_RED;
         end
         S_RED: begin
            cmd.op = OP_RED_STEP;
            if (sts.red_done) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (fn_ff) inside
               FUNC_ADD, FUNC_SUB: begin cmd.op = OP_ADDSUB; state_in = S_OUT; end
               FUNC_MUL: begin msel_in = MSEL_AB; state_in = S_MUL_START; end
               FUNC_POW: state_in = S_POW_TEST;
               FUNC_INV: state_in = sts.mod_small ? S_ERR : S_INV_START;
               default:  state_in = S_ERR;
            endcase
         end
         S_MUL_START: begin cmd.op = OP_MUL_INIT; state_in = S_MUL; end
         S_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (sts.mul_done) state_in = S_MUL_END;
         end
         S_MUL_END: begin
            cmd.op = OP_MUL_DONE;
            unique case (msel_ff)
               MSEL_AB:  state_in = S_OUT;
               MSEL_ACC: begin msel_in = MSEL_SQ; state_in = S_MUL_START; end
               default:  state_in = S_POW_SQ;
            endcase
         end
         S_POW_TEST: begin
            if (sts.exp_zero) begin
               cmd.op = OP_EXP_SHIFT; state_in = S_OUT;
            end else begin
               msel_in  = sts.exp_lsb ? MSEL_ACC : MSEL_SQ;
               state_in = S_MUL_START;
            end
         end
         S_POW_SQ: begin cmd.op = OP_EXP_SHIFT; state_in = S_POW_TEST; end
         S_INV_START: begin cmd.op = OP_INV_INIT; state_in = S_INV_TEST; end
         S_INV_TEST: begin
            if (sts.nr_zero) begin
               cmd.op = OP_INV_FIN; state_in = S_OUT;
            end else begin
               cmd.op = OP_DIV_INIT; state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (sts.div_done) state_in = S_INV_UPD;
         end
         S_INV_UPD: begin cmd.op = OP_INV_UPD; state_in = S_INV_TEST; end
         S_ERR: begin cmd.op = OP_ERROR; state_in = S_OUT; end
         S_OUT: begin
            rv_in = 1'b1;
            if (rv_ff && rsp_ready) begin rv_in = 1'b0; state_in = S_IDLE; end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fn_ff <= FUNC_ADD; msel_ff <= MSEL_AB; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fn_ff <= fn_in; msel_ff <= msel_in; rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
endmodule
`default_nettype wire

### src/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit: add, sub, mul, pow and inverse modulo a register
// Sequencer plus bit-serial datapath; one word in, one word out.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | func, operand_a, operand_b
//  rsp     | out | result_value, status
//  csr     | in  | modulus (write only)
// Each word first has its operands reduced bit-serially (cut short with modulus
// zero), then runs add/sub or the shift-add multiply; power runs a multiply
// and a square per set exponent bit and a square per clear one; inverse runs
// a restoring divide per Euclid step.
// Reset is synchronous; no state beyond the modulus survives a word.
// A held response stalls the unit; no new word is taken until it is read.
`default_nettype none
module modular_arithmetic_unit (
   input  wire        clock,
   input  wire        reset,
   mau_req_if.sink    req,
   mau_rsp_if.source  rsp,
   input  wire        csr_write,
   input  wire [31:0] csr_wdata
);
   import mau_pkg::*;

   word_type modulus_ff;
   cmd_type  cmd;
   sts_type  sts;

   // modulus register
   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= '0;
      else if (csr_write) modulus_ff <= csr_wdata;
   end

   mau_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_func(req.func),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd)
   );

   mau_datapath u_dp (
      .clock(clock), .reset(reset), .modulus(modulus_ff),
      .req_func(req.func), .req_a(req.operand_a), .req_b(req.operand_b),
      .cmd(cmd), .sts(sts), .result(rsp.result_value), .err(rsp.status)
   );
endmodule
`default_nettype wire

### src/mau_checker.sv
// ----------------------------------------------------------------------------
// mau_port_checks: port-level checks of the modular arithmetic unit
// Bound to the top level; watches the request and response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_port_checks (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_result_value,
   input wire        rsp_status
);
   // no word taken while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during response");
   // accepted word makes unit busy next cycle
   a_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
   // errors carry a zero result
   a_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_result_value == 32'd0))
      else $error("nonzero result on error");
   // response held until read
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_value)))
      else $error("response dropped");
endmodule

bind modular_arithmetic_unit mau_port_checks u_mau_port_checks (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_result_value(rsp.result_value), .rsp_status(rsp.status)
);
`default_nettype wire

### sim/mau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_checker: response scoreboard for the modular arithmetic unit
// Watches the request, response and csr ports, predicts each response word
// from the accepted request and the current modulus, and compares in order.
// ----------------------------------------------------------------------------
module mau_checker
   import mau_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   mau_req_if         req,
   mau_rsp_if         rsp,
   input  wire        csr_write,
   input  wire [31:0] csr_wdata,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      word_type result_value;
      logic     status;
   } answer_type;

   typedef longint unsigned u64;

   answer_type answers_due[$];
   word_type   modulus;

   // reduce into [0, m) or to the operand width when m is zero
   function automatic u64 wrap(u64 x, u64 m);
      return (m != 0) ? x % m : x & 64'hFFFF_FFFF;
   endfunction

   function automatic u64 power_mod(u64 base, u64 e, u64 m);
      u64 acc;
      u64 sq;
      acc = wrap(1, m);
      sq  = wrap(base, m);
      while (e != 0) begin
         if (e[0])
            acc = wrap(acc * sq, m);
         sq = wrap(sq * sq, m);
         e  = e >> 1;
      end
      return acc;
   endfunction

   // extended Euclid; status 1 when no inverse exists
   function automatic answer_type inverse_mod(u64 a, u64 m);
      answer_type ans;
      longint t, nt, tmp;
      u64 r, nr, q, tr;
      ans = '{result_value: '0, status: 1'b1};
      if (m < 2)
         return ans;
      t  = 0;
      nt = 1;
      r  = m;
      nr = a % m;
      while (nr != 0) begin
         q   = r / nr;
         tmp = t - longint'(q) * nt;
         t   = nt;
         nt  = tmp;
         tr  = r - q * nr;
         r   = nr;
         nr  = tr;
      end
      if (r != 1)
         return ans;
      if (t < 0)
         t = t + longint'(m);
      ans.result_value = word_type'(t);
      ans.status       = 1'b0;
      return ans;
   endfunction

   function automatic answer_type compute_answer(func_type f, word_type op_a, word_type op_b,
                                                 word_type mod_val);
      answer_type ans;
      u64 m, a, b;
      m   = mod_val;
      a   = wrap(op_a, m);
      b   = wrap(op_b, m);
      ans = '{result_value: '0, status: 1'b0};
      case (f)
         FUNC_ADD: ans.result_value = word_type'(wrap(a + b, m));
         FUNC_SUB: begin
            if (m != 0)
               ans.result_value = word_type'(wrap(a + (m - b), m));
            else
               ans.result_value = word_type'(wrap(a - b, m));
         end
         FUNC_MUL: ans.result_value = word_type'(wrap(a * b, m));
         FUNC_POW: ans.result_value = word_type'(power_mod(op_a, op_b, m));
         FUNC_INV: ans = inverse_mod(a, m);
         default:  ans.status = 1'b1;
      endcase
      return ans;
   endfunction

   // track modulus, queue predictions, compare responses
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         modulus = '0;
         answers_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_write)
            modulus = csr_wdata;
         if (req.valid && req.ready)
            answers_due.push_back(compute_answer(req.func, req.operand_a, req.operand_b,
                                                 modulus));
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
               if (fail_count < 10)
                  $display("mau_checker: unexpected word result=%h status=%b",
                           rsp.result_value, rsp.status);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (want.result_value !== rsp.result_value || want.status !== rsp.status) begin
                  if (fail_count < 10)
                     $display("mau_checker: mismatch exp result=%h status=%b got result=%h status=%b",
                              want.result_value, want.status, rsp.result_value, rsp.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= answers_due.size();
   end

endmodule

### sim/tb_modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_arithmetic_unit: stimulus and verdict for the arithmetic unit
// Directed corner words, then random words over several moduli with random
// idling on both channels, a long response hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_modular_arithmetic_unit;
   import mau_pkg::*;

   localparam int CycleLimit = 12_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          no_idle = 1'b0;
   int          hold_request = 0;
   int          hold_ack = 0;

   mau_req_if req ();
   mau_rsp_if rsp ();

   modular_arithmetic_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   mau_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr_write  (csr_write),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req.valid     = 1'b0;
      req.func      = FUNC_ADD;
      req.operand_a = '0;
      req.operand_b = '0;
      rsp.ready     = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_modular_arithmetic_unit NOT OK");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off on request
   always begin
      @(posedge clock);
      if (hold_request != hold_ack) begin
         rsp.ready <= 1'b0;
         repeat (3000) @(posedge clock);
         hold_ack = hold_request;
      end else begin
         rsp.ready <= no_idle || ($urandom_range(99) >= 6);
      end
   end

   // offer one word; valid stays high after acceptance until the next gap
   task automatic send_word(func_type f, word_type a, word_type b);
      if (!no_idle && $urandom_range(99) < 6) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req.valid     <= 1'b1;
      req.func      <= f;
      req.operand_a <= a;
      req.operand_b <= b;
      do @(posedge clock); while (!req.ready);
   endtask

   // drain all responses, then write the modulus
   task automatic set_modulus(word_type m);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic word_type pick_operand(word_type m);
      case ($urandom_range(5))
         0:       return $urandom_range(15);
         1:       return 32'hFFFF_FFFF - $urandom_range(3);
         2:       return (m != 0) ? m - $urandom_range(1) : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      word_type moduli[8];
      word_type m;
      func_type f;
      word_type a, b;

      moduli = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'd97,
                 32'h8000_0000, 32'h0001_0000};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wrap mode
      send_word(FUNC_ADD, 32'hFFFF_FFFF, 32'h1);
      send_word(FUNC_SUB, 32'h0, 32'h1);
      send_word(FUNC_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(FUNC_POW, 32'h3, 32'h0);
      send_word(FUNC_POW, 32'h0, 32'h5);
      send_word(FUNC_INV, 32'h3, 32'h0);
      send_word(3'd5, 32'h1, 32'h1);
      // directed: prime modulus
      set_modulus(32'd97);
      send_word(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(FUNC_SUB, 32'd3, 32'd96);
      send_word(FUNC_MUL, 32'd96, 32'd96);
      send_word(FUNC_POW, 32'd5, 32'hFFFF_FFFF);
      send_word(FUNC_POW, 32'd0, 32'd0);
      send_word(FUNC_POW, 32'd97, 32'd3);
      send_word(FUNC_INV, 32'd0, 32'd0);
      send_word(FUNC_INV, 32'd96, 32'hFFFF_FFFF);
      send_word(FUNC_INV, 32'd194, 32'd0);
      send_word(3'd6, 32'd7, 32'd7);
      send_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // directed: modulus one and a composite
      set_modulus(32'd1);
      send_word(FUNC_POW, 32'd9, 32'd0);
      send_word(FUNC_INV, 32'd1, 32'd0);
      set_modulus(32'd12);
      send_word(FUNC_INV, 32'd6, 32'd0);
      send_word(FUNC_INV, 32'd5, 32'd0);

      // random phases over the moduli
      for (int ph = 0; ph < 8; ph++) begin
         m = (ph == 6) ? word_type'($urandom) : moduli[ph];
         set_modulus(m);
         no_idle = (ph == 3);
         for (int i = 0; i < 35; i++) begin
            if (ph == 2 && i == 5)
               hold_request = hold_request + 1;
            if ($urandom_range(19) == 0)
               f = func_type'($urandom_range(7, 5));
            else
               f = func_type'($urandom_range(4));
            a = pick_operand(m);
            b = pick_operand(m);
            // keep most powers short; a few take a full exponent
            if (f == FUNC_POW && $urandom_range(9) != 0)
               b = $urandom_range(255);
            send_word(f, a, b);
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_modular_arithmetic_unit OK");
      else
         $display("tb_modular_arithmetic_unit NOT OK");
      $finish;
   end

endmodule
